// ===== rtl/rcw_pkg.sv =====
`timescale 1ns / 1ps

package rcw_pkg;

    localparam int WIN_W    = 32;
    localparam int HINT_W   = 31;
    localparam int ACKED_W  = 16;
    localparam int SEG_W    = 16;
    localparam int REQ_W    = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_ACK  = 2'd0,
        REQ_LOSS = 2'd1,
        REQ_FRTO = 2'd2,
        REQ_OPEN = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        REG_SLOW_START_LIMIT = 2'd0,
        REG_SEGMENT_SIZE     = 2'd1,
        REG_INITIAL_WINDOW   = 2'd2,
        REG_UNUSED           = 2'd3
    } reg_index_t;

    localparam logic [WIN_W-1:0] SSL_RESET  = 32'd65535;
    localparam logic [SEG_W-1:0] SEG_RESET  = 16'd1460;
    localparam logic [WIN_W-1:0] INIT_RESET = 32'd4380;
    localparam logic [WIN_W-1:0] WIN_MAX    = 32'hFFFF_FFFF;
    localparam logic [WIN_W-1:0] WIN_ONE    = 32'd1;

endpackage

// ===== rtl/reno_congestion_window_top.sv =====
`timescale 1ns / 1ps
// Ack items in congestion avoidance pass through EVAL, a 32-step restoring divider in DIV,
// ADD and FINISH before the result is valid; the next item is accepted only once the
// sequencer is back in IDLE. Loss, FRTO, open, slow-start acks and acks on a zero window
// go from EVAL straight to FINISH. The result sits in an output register: while it waits,
// the next item is taken and worked, then holds in its last step until the register frees.
// Reset (rst_n low, asynchronous) zeroes the window and loads the register defaults.
module reno_congestion_window_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rcw_pkg::ADDR_W-1:0]    paddr,
    input  logic [rcw_pkg::DATA_W-1:0]    pwdata,
    output logic [rcw_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [rcw_pkg::REQ_W-1:0]     req_type,
    input  logic [rcw_pkg::ACKED_W-1:0]   acked_bytes,
    // result channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [rcw_pkg::WIN_W-1:0]     window,
    output logic [rcw_pkg::HINT_W-1:0]    threshold_hint
);
    import rcw_pkg::*;

    // Sequencer: EVAL resolves the cheap cases, DIV runs the divider one
    // quotient bit per cycle, ADD applies the minimum-one rule and saturation,
    // FINISH hands the new window to the output register.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_ADD,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    req_kind_t           kind_reg;
    logic [ACKED_W-1:0]  acked_reg;
    logic [WIN_W-1:0]    cong_window_reg;
    logic [WIN_W-1:0]    result_reg;
    logic [WIN_W-1:0]    quo_reg;
    logic [WIN_W:0]      rem_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                rsp_valid_reg;
    logic [WIN_W-1:0]    window_reg;

    logic [WIN_W-1:0]    ssl_reg;
    logic [SEG_W-1:0]    seg_reg;
    logic [WIN_W-1:0]    init_reg;

    // ------------------------------------------------------------------
    // Configuration registers: written on the access phase of a write.
    // ------------------------------------------------------------------
    logic       cfg_write;
    reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssl_reg  <= SSL_RESET;
            seg_reg  <= SEG_RESET;
            init_reg <= INIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SLOW_START_LIMIT: ssl_reg  <= pwdata;
                REG_SEGMENT_SIZE:     seg_reg  <= pwdata[SEG_W-1:0];
                REG_INITIAL_WINDOW:   init_reg <= pwdata;
                REG_UNUSED:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_SLOW_START_LIMIT: prdata = ssl_reg;
            REG_SEGMENT_SIZE:     prdata = {{(DATA_W-SEG_W){1'b0}}, seg_reg};
            REG_INITIAL_WINDOW:   prdata = init_reg;
            REG_UNUSED:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath pieces used by the sequencer.
    // ------------------------------------------------------------------
    logic               req_accept;
    logic               out_free;
    logic [WIN_W:0]     ss_sum;
    logic [WIN_W-1:0]   ss_capped;
    logic [WIN_W-1:0]   product;
    logic [WIN_W:0]     rem_shift;
    logic [WIN_W+1:0]   trial;
    logic [WIN_W-1:0]   incr;
    logic [WIN_W:0]     ca_sum;
    logic [WIN_W-1:0]   ca_sat;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    // Slow start: add wide, cap at the limit.
    assign ss_sum    = {1'b0, cong_window_reg} + {{(WIN_W+1-ACKED_W){1'b0}}, acked_reg};
    assign ss_capped = (ss_sum > {1'b0, ssl_reg}) ? ssl_reg : ss_sum[WIN_W-1:0];

    // 16x16 product is the dividend of the increment.
    assign product = WIN_W'(seg_reg) * WIN_W'(acked_reg);

    // One restoring step: shift in the next dividend bit, try the subtract.
    assign rem_shift = {rem_reg[WIN_W-1:0], quo_reg[WIN_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, cong_window_reg};

    // Raise a zero increment to one, then saturate the sum.
    assign incr   = (quo_reg == '0) ? WIN_ONE : quo_reg;
    assign ca_sum = {1'b0, cong_window_reg} + {1'b0, incr};
    assign ca_sat = ca_sum[WIN_W] ? WIN_MAX : ca_sum[WIN_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            kind_reg        <= REQ_ACK;
            acked_reg       <= '0;
            cong_window_reg <= '0;
            result_reg      <= '0;
            quo_reg         <= '0;
            rem_reg         <= '0;
            count_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
            window_reg      <= '0;
        end
        else
        begin
            // drop the result once the consumer takes it, unless FINISH refills it
            if (rsp_valid_reg && !rsp_stall && state_reg != ST_FINISH)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_accept)
                    begin
                        kind_reg  <= req_kind_t'(req_type);
                        acked_reg <= acked_bytes;
                        state_reg <= ST_EVAL;
                    end
                end

                ST_EVAL:
                begin
                    priority if (kind_reg == REQ_LOSS)
                    begin
                        result_reg <= WIN_ONE;
                        state_reg  <= ST_FINISH;
                    end
                    else if (kind_reg == REQ_FRTO || kind_reg == REQ_OPEN)
                    begin
                        result_reg <= init_reg;
                        state_reg  <= ST_FINISH;
                    end
                    else if (cong_window_reg == '0)
                    begin
                        // hold a zero window on ack
                        result_reg <= cong_window_reg;
                        state_reg  <= ST_FINISH;
                    end
                    else if (cong_window_reg < ssl_reg)
                    begin
                        result_reg <= ss_capped;
                        state_reg  <= ST_FINISH;
                    end
                    else
                    begin
                        // load the dividend and start the divider
                        quo_reg   <= product;
                        rem_reg   <= '0;
                        count_reg <= CNT_W'(WIN_W - 1);
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    if (!trial[WIN_W+1])
                    begin
                        rem_reg <= trial[WIN_W:0];
                        quo_reg <= {quo_reg[WIN_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift;
                        quo_reg <= {quo_reg[WIN_W-2:0], 1'b0};
                    end
                    if (count_reg == '0)
                    begin
                        state_reg <= ST_ADD;
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                end

                ST_ADD:
                begin
                    result_reg <= ca_sat;
                    state_reg  <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    // wait until the output register is free
                    if (out_free)
                    begin
                        cong_window_reg <= result_reg;
                        window_reg      <= result_reg;
                        rsp_valid_reg   <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign window         = window_reg;
    assign threshold_hint = window_reg[WIN_W-1:1];

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// Block-level test of the Reno congestion window.
// Items go in on the request channel one at a time. A behavioral copy of the
// window update runs beside the block and queues one expected window per
// accepted item. The result channel is compared against the oldest queued
// window, field by field. Registers are written over the APB-style port only
// while the block is drained, and each write is read back.

module testbench;

    import rcw_pkg::*;

    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 12;
    // Longest correct run of cycles with no transfer on any port: a full divide,
    // a long receiver hold-off, a drain pause. Leave a wide margin.
    localparam int unsigned QUIET_LIMIT  = 20000;
    // Settle time after the last result before touching registers or ending.
    localparam int          SETTLE_CYCLES = 40;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          ITEMS_PER_SETTING = 100;

    typedef struct packed {
        logic [WIN_W-1:0]  win;
        logic [HINT_W-1:0] hint;
    } cwnd_answer_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [REQ_W-1:0]     req_type = '0;
    logic [ACKED_W-1:0]   acked_bytes = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [WIN_W-1:0]     window;
    logic [HINT_W-1:0]    threshold_hint;

    // Shadow copy of the block's registers and window.
    logic [WIN_W-1:0]     model_ss_limit;
    logic [SEG_W-1:0]     model_seg;
    logic [WIN_W-1:0]     model_init_win;
    logic [WIN_W-1:0]     model_cwnd;

    cwnd_answer_t         pending_answers[$];
    int unsigned          error_count = 0;
    int unsigned          src_idle_pct = 0;
    int unsigned          rsp_idle_pct = 0;
    int unsigned          rsp_hold_cycles = 0;

    reno_congestion_window_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .acked_bytes    (acked_bytes),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .window         (window),
        .threshold_hint (threshold_hint)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Window after one item, from the shadow state.
    // Loss collapses the window to one, FRTO and open reload, acks grow a
    // nonzero window by slow start below the limit or by congestion
    // avoidance at or above it. Both sums are formed wide and clamped.
    function automatic logic [WIN_W-1:0] next_cwnd(input req_kind_t kind,
                                                   input logic [ACKED_W-1:0] acked);
        logic [63:0] grown;
        logic [63:0] step;
        next_cwnd = model_cwnd;
        if (kind == REQ_LOSS)
        begin
            next_cwnd = WIN_ONE;
        end
        else if (kind != REQ_ACK)
        begin
            next_cwnd = model_init_win;
        end
        else if (model_cwnd != '0)
        begin
            if (model_cwnd < model_ss_limit)
            begin
                grown = 64'(model_cwnd) + 64'(acked);
                if (grown > 64'(model_ss_limit))
                begin
                    grown = 64'(model_ss_limit);
                end
            end
            else
            begin
                step = (64'(model_seg) * 64'(acked)) / 64'(model_cwnd);
                if (step == 64'd0)
                begin
                    step = 64'd1;
                end
                grown = 64'(model_cwnd) + step;
                if (grown > 64'(WIN_MAX))
                begin
                    grown = 64'(WIN_MAX);
                end
            end
            next_cwnd = grown[WIN_W-1:0];
        end
    endfunction

    function automatic logic [DATA_W-1:0] shadow_reg(input reg_index_t idx);
        case (idx)
            REG_SLOW_START_LIMIT: shadow_reg = model_ss_limit;
            REG_SEGMENT_SIZE:     shadow_reg = DATA_W'(model_seg);
            REG_INITIAL_WINDOW:   shadow_reg = model_init_win;
            default:              shadow_reg = '0;
        endcase
    endfunction

    // Offer one item, hold it until accepted, then queue its window.
    // Entered and left at a falling edge; valid stays high on exit so that
    // a back-to-back item does not drop it.
    task automatic send_item(input req_kind_t kind, input logic [ACKED_W-1:0] acked);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            // Idle cycle: drop valid and scramble the payload.
            req_valid   <= 1'b0;
            req_type    <= REQ_W'($urandom);
            acked_bytes <= ACKED_W'($urandom);
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        req_type    <= kind;
        acked_bytes <= acked;
        do
            @(posedge clk);
        while (req_stall);
        model_cwnd = next_cwnd(kind, acked);
        pending_answers.push_back('{win: model_cwnd, hint: model_cwnd[WIN_W-1:1]});
        @(negedge clk);
    endtask

    // Well-formed traffic is mostly acks after an open; mix in losses,
    // reloads and acked counts at both ends of the range.
    task automatic send_random_item();
        int unsigned pick;
        req_kind_t   kind;
        logic [ACKED_W-1:0] acked;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            kind = REQ_OPEN;
        else if (pick < 16)
            kind = REQ_FRTO;
        else if (pick < 23)
            kind = REQ_LOSS;
        else
            kind = REQ_ACK;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            acked = '0;
        else if (pick == 1)
            acked = '1;
        else if (pick < 5)
            acked = ACKED_W'($urandom_range(1, 3000));
        else
            acked = ACKED_W'($urandom);
        send_item(kind, acked);
    endtask

    // Drop valid, wait out every queued window, then let the block settle.
    task automatic drain_answers();
        req_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register (setup then access), mirror it, and read it back.
    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_SLOW_START_LIMIT: model_ss_limit = value;
            REG_SEGMENT_SIZE:     model_seg      = value[SEG_W-1:0];
            REG_INITIAL_WINDOW:   model_init_win = value;
            default:              ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        if (idx != REG_UNUSED && readback !== shadow_reg(idx))
        begin
            $error("prdata of %s: expected %0d, got %0d", idx.name(), shadow_reg(idx),
                   readback);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Pick register values with weight on the extremes.
    task automatic program_random_setting();
        logic [WIN_W-1:0] limit;
        logic [SEG_W-1:0] seg;
        logic [WIN_W-1:0] init_win;
        case ($urandom_range(0, 5))
            0:       limit = 32'd1;
            1:       limit = WIN_MAX;
            2:       limit = '0;
            3:       limit = $urandom;
            default: limit = $urandom_range(1, 200000);
        endcase
        case ($urandom_range(0, 4))
            0:       seg = '0;
            1:       seg = '1;
            2:       seg = 16'd1;
            default: seg = SEG_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       init_win = 32'd1;
            1:       init_win = WIN_MAX;
            2:       init_win = WIN_MAX - $urandom_range(0, 70000);
            3:       init_win = $urandom;
            default: init_win = $urandom_range(1, 100000);
        endcase
        write_reg(REG_SLOW_START_LIMIT, limit);
        // Upper data bits are junk; the block keeps only the low half.
        write_reg(REG_SEGMENT_SIZE, {16'($urandom), seg});
        write_reg(REG_INITIAL_WINDOW, init_win);
    endtask

    // An ack before any open leaves the zero window alone.
    task automatic test_ack_before_open();
        send_item(REQ_ACK, '1);
        send_item(REQ_ACK, '0);
    endtask

    // Open with junk acked bytes, grow, then hit the slow-start cap.
    task automatic test_slow_start();
        send_item(REQ_OPEN, '1);
        send_item(REQ_ACK, 16'd1000);
        send_item(REQ_ACK, '1);
    endtask

    // At the limit, grow by mss*acked/window; zero acked still adds one.
    task automatic test_congestion_avoidance();
        send_item(REQ_ACK, '1);
        send_item(REQ_ACK, '0);
    endtask

    task automatic test_loss_and_reload();
        send_item(REQ_LOSS, '1);
        send_item(REQ_ACK, 16'd1);
        send_item(REQ_FRTO, 16'h5A5A);
        send_item(REQ_LOSS, '0);
        send_item(REQ_OPEN, '0);
    endtask

    // Register extremes: zero segment size, zero limit, a full window that
    // must saturate, a wide slow-start sum, and a zero initial window.
    task automatic test_register_edges();
        drain_answers();
        write_reg(REG_SEGMENT_SIZE, 32'hABCD_0000);
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_SLOW_START_LIMIT, '0);
        write_reg(REG_INITIAL_WINDOW, WIN_MAX);
        send_item(REQ_OPEN, '0);
        send_item(REQ_ACK, '1);
        drain_answers();
        write_reg(REG_SLOW_START_LIMIT, WIN_MAX);
        write_reg(REG_INITIAL_WINDOW, 32'hFFFF_FFF0);
        send_item(REQ_OPEN, '0);
        send_item(REQ_ACK, '1);
        drain_answers();
        write_reg(REG_INITIAL_WINDOW, '0);
        send_item(REQ_FRTO, '0);
        send_item(REQ_ACK, 16'd77);
        drain_answers();
        write_reg(REG_SLOW_START_LIMIT, SSL_RESET);
        write_reg(REG_SEGMENT_SIZE, 32'(SEG_RESET));
        write_reg(REG_INITIAL_WINDOW, INIT_RESET);
    endtask

    // Hold the result side for a long stretch while items keep coming, so
    // the output register fills and the request side stalls.
    task automatic test_backpressure();
        drain_answers();
        src_idle_pct    = 0;
        rsp_idle_pct    = 0;
        rsp_hold_cycles = HOLD_OFF_CYCLES;
        send_item(REQ_OPEN, '0);
        repeat (19) send_random_item();
    endtask

    task automatic test_random_traffic();
        int unsigned src_pcts[3] = '{16, 69, 0};
        int unsigned rsp_pcts[3] = '{69, 16, 0};
        for (int p = 0; p < 3; p++)
        begin
            for (int s = 0; s < 3; s++)
            begin
                drain_answers();
                src_idle_pct = src_pcts[p];
                rsp_idle_pct = rsp_pcts[p];
                program_random_setting();
                send_item(REQ_OPEN, ACKED_W'($urandom));
                repeat (ITEMS_PER_SETTING - 1) send_random_item();
            end
        end
    endtask

    // Result side: hold off when asked, otherwise stall at random.
    always @(negedge clk)
    begin
        if (rsp_hold_cycles != 0)
        begin
            rsp_stall <= 1'b1;
            rsp_hold_cycles = rsp_hold_cycles - 1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
        end
    end

    // Compare each accepted result with the oldest queued window.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result with nothing queued: window %0d, threshold_hint %0d",
                       window, threshold_hint);
                error_count++;
            end
            else
            begin
                cwnd_answer_t want;
                want = pending_answers.pop_front();
                if (window !== want.win)
                begin
                    $error("window: expected %0d, got %0d", want.win, window);
                    error_count++;
                end
                if (threshold_hint !== want.hint)
                begin
                    $error("threshold_hint: expected %0d, got %0d", want.hint,
                           threshold_hint);
                    error_count++;
                end
            end
        end
    end

    // End the run if no port moves anything for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        model_ss_limit = SSL_RESET;
        model_seg      = SEG_RESET;
        model_init_win = INIT_RESET;
        model_cwnd     = '0;
        src_idle_pct   = 16;
        rsp_idle_pct   = 69;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_ack_before_open();
        test_slow_start();
        test_congestion_avoidance();
        test_loss_and_reload();
        test_register_edges();
        test_backpressure();
        test_random_traffic();
        drain_answers();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
